>>> src/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg: shared definitions for the chained hash key set
// Field widths, operation and status codes, controller states, the bucket
// remainder unit's request and response structs, and parameter defaults.
// ----------------------------------------------------------------------------
package chs_pkg;

  // Field widths.
  localparam int KEY_W = 31;
  localparam int OP_W  = 2;
  localparam int STS_W = 2;
  localparam int BC_W  = 5;

  // Bucket count after reset.
  localparam logic [BC_W-1:0] BC_RESET = BC_W'(10);

  // Parameter defaults for the top level.
  localparam int DEF_NUM_BUCKETS = 16;
  localparam int DEF_CHAIN_DEPTH = 8;

  // Remainder unit: key bits consumed per cycle and the resulting cycle count.
  localparam int MOD_STEPS  = 8;
  localparam int MOD_CYCLES = (KEY_W + MOD_STEPS - 1) / MOD_STEPS;
  localparam int MOD_PAD_W  = MOD_CYCLES * MOD_STEPS;
  localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

  // Operation codes; the fourth code leaves the table alone.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    STS_DONE   = 2'd0,
    STS_ABSENT = 2'd1,
    STS_FULL   = 2'd2
  } sts_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_RESULT
  } state_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
    logic [BC_W-1:0]  divisor;
  } mod_req_t;

  // Response from the remainder unit.
  typedef struct packed {
    logic            done;
    logic [BC_W-1:0] rem;
  } mod_rsp_t;

endpackage

>>> src/chained_hash_key_set.sv
// Each item: the key modulo the bucket count, a scan of the bucket's slots up
// to a hit or the last of the CHAIN_DEPTH slots (eight by default), and then
// the result is posted; an unused operation posts without touching the table.
// One item at a time: the next is taken in the idle state once the result of
// the last has been posted, so a stalled output side holds the input back.
// Reset: synchronous, active low; a clearing pass empties the table first.
// ----------------------------------------------------------------------------
// chained_hash_key_set: keyed set as a hash table with separate chaining
// Each bucket owns CHAIN_DEPTH consecutive memory words of {valid, key}.
// Insert fills the lowest free slot, delete clears the lowest matching one,
// search reports a match.
// ----------------------------------------------------------------------------
module chained_hash_key_set #(
  parameter int NUM_BUCKETS = chs_pkg::DEF_NUM_BUCKETS,
  parameter int CHAIN_DEPTH = chs_pkg::DEF_CHAIN_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [chs_pkg::BC_W-1:0]  cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [chs_pkg::OP_W-1:0]  in_operation,
  input  logic [chs_pkg::KEY_W-1:0] in_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [chs_pkg::STS_W-1:0] out_status
);

  localparam int TOTAL  = NUM_BUCKETS * CHAIN_DEPTH;
  localparam int AW     = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SLOT_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int ISS_W  = $clog2(CHAIN_DEPTH + 1);
  localparam int NB_CAP = (NUM_BUCKETS < 31) ? NUM_BUCKETS : 31;
  localparam int ENT_W  = chs_pkg::KEY_W + 1;

  chs_pkg::state_t state_r, state_nxt;

  logic [chs_pkg::BC_W-1:0]  bc_r;
  logic [chs_pkg::BC_W-1:0]  active_bc;
  chs_pkg::op_t              op_r, op_nxt;
  logic [chs_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [AW-1:0]             base_r, base_nxt;
  logic [AW-1:0]             clr_addr_r, clr_addr_nxt;
  logic [ISS_W-1:0]          iss_r, iss_nxt;
  logic                      pend_r, pend_nxt;
  logic [SLOT_W-1:0]         rd_slot_r, rd_slot_nxt;
  logic                      res_found_r, res_found_nxt;
  chs_pkg::sts_t             res_sts_r, res_sts_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  chs_pkg::sts_t             out_sts_r, out_sts_nxt;

  logic                      accept;
  logic                      clr_last;
  logic                      hit;
  logic                      last_slot;
  logic                      can_post;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [ENT_W-1:0]          ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [ENT_W-1:0]          ram_rdata;
  logic                      ent_valid;
  logic [chs_pkg::KEY_W-1:0] ent_key;

  chs_pkg::mod_req_t mod_req;
  chs_pkg::mod_rsp_t mod_rsp;

  // Slot memory: one {valid, key} word per slot.
  chs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TOTAL),
    .ADDR_W(AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Bucket selection: key modulo the active bucket count.
  chs_mod u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mod_req),
    .rsp  (mod_rsp)
  );

  // Bucket count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r <= chs_pkg::BC_RESET;
    end else if (cfg_wr_en) begin
      bc_r <= cfg_wr_data;
    end
  end

  // Zero counts as one bucket; values beyond the table saturate.
  always_comb begin
    if (bc_r == '0) begin
      active_bc = chs_pkg::BC_W'(1);
    end else if (bc_r > chs_pkg::BC_W'(NB_CAP)) begin
      active_bc = chs_pkg::BC_W'(NB_CAP);
    end else begin
      active_bc = bc_r;
    end
  end

  // Handshake and scan decode.
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != chs_pkg::S_IDLE);
  assign clr_last  = (clr_addr_r == AW'(TOTAL - 1));
  assign ent_valid = ram_rdata[ENT_W-1];
  assign ent_key   = ram_rdata[chs_pkg::KEY_W-1:0];
  assign last_slot = (rd_slot_r == SLOT_W'(CHAIN_DEPTH - 1));
  assign can_post  = !out_valid_r || !out_stall;
  assign hit       = pend_r && ((op_r == chs_pkg::OP_INSERT) ? !ent_valid
                                : (ent_valid && (ent_key == key_r)));

  assign mod_req.start    = accept && (chs_pkg::op_t'(in_operation) != chs_pkg::OP_NONE);
  assign mod_req.dividend = in_key;
  assign mod_req.divisor  = active_bc;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chs_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    base_r      <= base_nxt;
    rd_slot_r   <= rd_slot_nxt;
    res_found_r <= res_found_nxt;
    res_sts_r   <= res_sts_nxt;
    out_found_r <= out_found_nxt;
    out_sts_r   <= out_sts_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chs_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_nxt = chs_pkg::S_IDLE;
        end
      end
      chs_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (chs_pkg::op_t'(in_operation) == chs_pkg::OP_NONE) ?
                      chs_pkg::S_RESULT : chs_pkg::S_MOD;
        end
      end
      chs_pkg::S_MOD: begin
        if (mod_rsp.done) begin
          state_nxt = chs_pkg::S_SCAN;
        end
      end
      chs_pkg::S_SCAN: begin
        if (hit || (pend_r && last_slot)) begin
          state_nxt = chs_pkg::S_RESULT;
        end
      end
      chs_pkg::S_RESULT: begin
        if (can_post) begin
          state_nxt = chs_pkg::S_IDLE;
        end
      end
      default: state_nxt = chs_pkg::S_CLEAR;
    endcase
  end

  // Datapath, memory access and result posting.
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    base_nxt      = base_r;
    clr_addr_nxt  = clr_addr_r;
    iss_nxt       = iss_r;
    pend_nxt      = 1'b0;
    rd_slot_nxt   = rd_slot_r;
    res_found_nxt = res_found_r;
    res_sts_nxt   = res_sts_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_sts_nxt   = out_sts_r;
    ram_we        = 1'b0;
    ram_waddr     = base_r + AW'(rd_slot_r);
    ram_wdata     = {1'b1, key_r};
    ram_raddr     = base_r + AW'(iss_r);
    unique case (state_r)
      chs_pkg::S_CLEAR: begin
        // Clearing pass: one slot emptied per cycle.
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      chs_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt        = chs_pkg::op_t'(in_operation);
          key_nxt       = in_key;
          res_found_nxt = 1'b0;
          res_sts_nxt   = chs_pkg::STS_DONE;
        end
      end
      chs_pkg::S_MOD: begin
        // Bucket base address; the scan restarts at slot zero.
        if (mod_rsp.done) begin
          base_nxt = AW'(32'(mod_rsp.rem) * CHAIN_DEPTH);
          iss_nxt  = '0;
        end
      end
      chs_pkg::S_SCAN: begin
        // Issue the next slot read while checking the previous one's data.
        if (iss_r != ISS_W'(CHAIN_DEPTH)) begin
          pend_nxt    = 1'b1;
          rd_slot_nxt = SLOT_W'(iss_r);
          iss_nxt     = iss_r + 1'b1;
        end
        if (hit) begin
          pend_nxt = 1'b0;
          unique case (op_r)
            chs_pkg::OP_INSERT: begin
              ram_we      = 1'b1;
              ram_wdata   = {1'b1, key_r};
              res_sts_nxt = chs_pkg::STS_DONE;
            end
            chs_pkg::OP_DELETE: begin
              ram_we        = 1'b1;
              ram_wdata     = {1'b0, key_r};
              res_found_nxt = 1'b1;
              res_sts_nxt   = chs_pkg::STS_DONE;
            end
            chs_pkg::OP_SEARCH: begin
              res_found_nxt = 1'b1;
              res_sts_nxt   = chs_pkg::STS_DONE;
            end
            default: begin
              res_sts_nxt = chs_pkg::STS_DONE;
            end
          endcase
        end else if (pend_r && last_slot) begin
          pend_nxt    = 1'b0;
          res_sts_nxt = (op_r == chs_pkg::OP_INSERT) ? chs_pkg::STS_FULL
                                                     : chs_pkg::STS_ABSENT;
        end
      end
      chs_pkg::S_RESULT: begin
        // Move the result into the output register once it is free.
        if (can_post) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_sts_nxt   = res_sts_r;
        end
      end
      default: begin
        clr_addr_nxt = '0;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_status = out_sts_r;

endmodule

>>> src/chs_ram.sv
// ----------------------------------------------------------------------------
// chs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/chs_mod.sv
// ----------------------------------------------------------------------------
// chs_mod: key modulo bucket count
// Digit-serial remainder: MOD_STEPS key bits per cycle, each step a doubling
// plus one compare and subtract on a five-bit remainder.
// ----------------------------------------------------------------------------
module chs_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  chs_pkg::mod_req_t req,
  output chs_pkg::mod_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [chs_pkg::MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [chs_pkg::MOD_PAD_W-1:0] sh_r, sh_nxt;
  logic [chs_pkg::BC_W-1:0]      rem_r, rem_nxt;
  logic [chs_pkg::BC_W-1:0]      div_r, div_nxt;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  // One cycle of the remainder recurrence, or a fresh load on start.
  always_comb begin
    logic [chs_pkg::BC_W:0]        t;
    logic [chs_pkg::BC_W-1:0]      r;
    logic [chs_pkg::MOD_PAD_W-1:0] sh;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    r        = rem_r;
    sh       = sh_r;
    for (int i = 0; i < chs_pkg::MOD_STEPS; i++) begin
      t = {r, sh[chs_pkg::MOD_PAD_W-1]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      r  = t[chs_pkg::BC_W-1:0];
      sh = sh << 1;
    end
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = chs_pkg::MOD_PAD_W'(req.dividend);
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      sh_nxt  = sh;
      rem_nxt = r;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == chs_pkg::MOD_CNT_W'(chs_pkg::MOD_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

>>> src/chs_checker.sv
// ----------------------------------------------------------------------------
// chs_checker: port-level checks for the chained hash key set
// Watches the item channels and flags results or handshakes that break the
// block's behaviour over time.
// ----------------------------------------------------------------------------
module chs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_found,
  input logic [chs_pkg::STS_W-1:0] out_status
);

  // A stalled result item holds its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_status))
    else $error("result item changed while stalled");

  // One item at a time: after an accept the input side stalls.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in progress");

  // Out of reset the input side stalls: the clearing pass runs before any item is taken.
  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("item taken during the clearing pass");

  // A found key always reports done, and a full bucket never reports found.
  a_found_sts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == chs_pkg::STS_DONE)
    else $error("found item with a status other than done");

endmodule

bind chained_hash_key_set chs_checker u_chs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_found (out_found),
  .out_status(out_status)
);
